// ===== hdl/gde_pkg.sv =====
// Shared package of the Gaussian density evaluator: field widths, register
// indexes, fixed-point constants and the elaboration-time exp table builder.
// No dependencies.
`default_nettype none

package gde_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned DENS_W = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam int unsigned MAG_W = 24;
  localparam int unsigned SQ_W = 32;
  localparam int unsigned TERM_W = 48;
  localparam int unsigned Y_W = 33;
  localparam int unsigned ROM_W = 31;
  localparam int unsigned PROD_W = 63;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned VAL_SHIFT = 30;
  localparam int unsigned MAX_EXP_N = 33;

  localparam int unsigned EXP_TABLE_ENTRIES_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF = 24;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_TWO_VAR_X = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_TWO_VAR_Y = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_SCALE = 3'd4;

  localparam logic [COORD_W-1:0] CENTER_RESET = 32'd0;
  localparam logic [COEF_W-1:0] INV_TWO_VAR_RESET = 32'd8388608;
  localparam logic [COEF_W-1:0] PEAK_SCALE_RESET = 32'd2670177;

  // Evaluates e^(-x) in Q30 with a Taylor series up to x^24; used only to build
  // the constant table at elaboration.
  function automatic logic [ROM_W-1:0] exp_q30(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum = ONE_Q30;
    term = ONE_Q30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * x) >> 30) / 64'(k);
      if ((k % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum[ROM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gde_axis.sv =====
// One axis of the exponent argument: offset from the center, saturated square
// and coefficient product over three register stages. Depends on gde_pkg.
`default_nettype none

module gde_axis (
  input  wire logic                              clk,
  input  wire logic [2:0]                        en,
  input  wire logic signed [gde_pkg::COORD_W-1:0] point,
  input  wire logic signed [gde_pkg::COORD_W-1:0] center,
  input  wire logic [gde_pkg::COEF_W-1:0]        coef,
  output logic [gde_pkg::TERM_W-1:0]             term
);

  logic signed [gde_pkg::COORD_W:0] diff;
  logic [gde_pkg::COORD_W:0]        mag_full;
  logic [gde_pkg::MAG_W-1:0]        mag;
  logic                             big;
  logic [2*gde_pkg::MAG_W-1:0]      mag_sq;
  logic [gde_pkg::SQ_W-1:0]         sq;
  logic [2*gde_pkg::SQ_W-1:0]       sq_coef;

  assign diff = {point[gde_pkg::COORD_W-1], point} - {center[gde_pkg::COORD_W-1], center};
  assign mag_full = diff[gde_pkg::COORD_W] ? (~diff + 1'b1) : diff;
  assign mag_sq = mag * mag;
  assign sq_coef = {{gde_pkg::SQ_W{1'b0}}, sq} * {{gde_pkg::SQ_W{1'b0}}, coef};

  // A magnitude of 2^24 or more squares past the saturation point.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag <= mag_full[gde_pkg::MAG_W-1:0];
      big <= |mag_full[gde_pkg::COORD_W:gde_pkg::MAG_W];
    end
    if (en[1]) begin
      sq <= big ? {gde_pkg::SQ_W{1'b1}} : mag_sq[2*gde_pkg::MAG_W-1:16];
    end
    if (en[2]) begin
      term <= sq_coef[2*gde_pkg::SQ_W-1:16];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gde_exp.sv =====
// Base-2 exponential unit: scales the argument by log2(e), splits it into a
// shift count and a fraction, and interpolates a constant table of 2^(-i/N).
// Four register stages. Depends on gde_pkg.
`default_nettype none

module gde_exp #(
  parameter int unsigned EXP_TABLE_ENTRIES = gde_pkg::EXP_TABLE_ENTRIES_DEF,
  parameter int unsigned FRAC_BITS = gde_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic [3:0]                         en,
  input  wire logic [gde_pkg::COORD_W-1:0]        arg,
  output logic [gde_pkg::ROM_W-1:0]               val,
  output logic [gde_pkg::Y_W-FRAC_BITS-1:0]       shift_n
);

  localparam int unsigned NW = gde_pkg::Y_W - FRAC_BITS;
  localparam int unsigned IW = $clog2(EXP_TABLE_ENTRIES);
  localparam int unsigned RW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int unsigned PW = FRAC_BITS + RW;
  localparam int unsigned DW = gde_pkg::ROM_W + FRAC_BITS;

  logic [gde_pkg::ROM_W-1:0] rom [EXP_TABLE_ENTRIES+1];

  for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_rom
    localparam logic [63:0] ROM_X =
      (64'(gi) * gde_pkg::LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
    assign rom[gi] = gde_pkg::exp_q30(ROM_X);
  end

  logic [gde_pkg::PROD_W-1:0]  y_full;
  logic [gde_pkg::Y_W-1:0]     y;
  logic [PW-1:0]               p;
  logic [NW-1:0]               n_s6;
  logic [IW-1:0]               idx;
  logic [FRAC_BITS-1:0]        r_s6;
  logic [NW-1:0]               n_s7;
  logic [FRAC_BITS-1:0]        r_s7;
  logic [gde_pkg::ROM_W-1:0]   t0_rd;
  logic [gde_pkg::ROM_W-1:0]   t1_rd;
  logic [gde_pkg::ROM_W-1:0]   t0;
  logic [gde_pkg::ROM_W-1:0]   diff;
  logic [DW-1:0]               corr;

  assign y_full = gde_pkg::PROD_W'(arg) * gde_pkg::PROD_W'(gde_pkg::LOG2E_Q30);
  assign p = PW'(y[FRAC_BITS-1:0]) * PW'(EXP_TABLE_ENTRIES);
  assign t0_rd = rom[RW'(idx)];
  assign t1_rd = rom[RW'(idx) + RW'(1)];
  assign corr = DW'(diff) * DW'(r_s7);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y <= y_full[gde_pkg::PROD_W-1:30];
    end
    if (en[1]) begin
      n_s6 <= y[gde_pkg::Y_W-1:FRAC_BITS];
      idx  <= p[FRAC_BITS+IW-1:FRAC_BITS];
      r_s6 <= p[FRAC_BITS-1:0];
    end
    if (en[2]) begin
      n_s7 <= n_s6;
      r_s7 <= r_s6;
      t0   <= t0_rd;
      diff <= (t0_rd >= t1_rd) ? t0_rd - t1_rd : '0;
    end
    if (en[3]) begin
      shift_n <= n_s7;
      val     <= t0 - corr[DW-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gaussian_2d_density_eval_unit.sv =====
// Top level of the axis-aligned bivariate Gaussian density evaluator:
// configuration registers, pipeline flow control, argument sum and output
// scaling. Depends on gde_pkg, gde_axis and gde_exp.
//
// Usage: query points enter on the in channel (in_valid/in_ready with
// point_x, point_y) and densities leave on the out channel (out_valid/
// out_ready with density, underflowed), one result per point, in order.
// The pipeline has ten register stages. A result is presented on the out
// channel from the last stage and leaves when the receiver takes it; one point
// is taken every cycle while the receiver keeps up. The ten stages hold their
// own valid bits and each stage moves when the one after it is empty or
// moving, so bubbles are squeezed out while the receiver stalls; in_ready
// falls only once every stage holds an item.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once
// and belong only to idle periods; indexes past the last register are ignored.
// A synchronous reset empties the pipeline and loads the default center
// (origin), coefficients and peak scale; there is no clearing sequence.
`default_nettype none

module gaussian_2d_density_eval_unit #(
  parameter int unsigned EXP_TABLE_ENTRIES = gde_pkg::EXP_TABLE_ENTRIES_DEF,
  parameter int unsigned FRAC_BITS = gde_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [gde_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [gde_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [gde_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [gde_pkg::COORD_W-1:0] point_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [gde_pkg::DENS_W-1:0]              density,
  output logic                                    underflowed
);

  localparam int unsigned NSTG = 10;
  localparam int unsigned NW = gde_pkg::Y_W - FRAC_BITS;

  logic signed [gde_pkg::COORD_W-1:0] center_x;
  logic signed [gde_pkg::COORD_W-1:0] center_y;
  logic [gde_pkg::COEF_W-1:0]         inv_two_var_x;
  logic [gde_pkg::COEF_W-1:0]         inv_two_var_y;
  logic [gde_pkg::COEF_W-1:0]         peak_scale;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  logic [gde_pkg::TERM_W-1:0]   term_x;
  logic [gde_pkg::TERM_W-1:0]   term_y;
  logic [gde_pkg::TERM_W:0]     arg_sum;
  logic [gde_pkg::COORD_W-1:0]  arg;
  logic [gde_pkg::ROM_W-1:0]    val;
  logic [NW-1:0]                shift_n;
  logic [gde_pkg::PROD_W-1:0]   prod;
  logic                         huge;
  logic [gde_pkg::SHIFT_W-1:0]  shift_amt;
  logic [gde_pkg::PROD_W-1:0]   shifted;
  logic [gde_pkg::DENS_W-1:0]   density_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= gde_pkg::CENTER_RESET;
      center_y      <= gde_pkg::CENTER_RESET;
      inv_two_var_x <= gde_pkg::INV_TWO_VAR_RESET;
      inv_two_var_y <= gde_pkg::INV_TWO_VAR_RESET;
      peak_scale    <= gde_pkg::PEAK_SCALE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gde_pkg::REG_CENTER_X:      center_x <= cfg_wdata;
        gde_pkg::REG_CENTER_Y:      center_y <= cfg_wdata;
        gde_pkg::REG_INV_TWO_VAR_X: inv_two_var_x <= cfg_wdata;
        gde_pkg::REG_INV_TWO_VAR_Y: inv_two_var_y <= cfg_wdata;
        gde_pkg::REG_PEAK_SCALE:    peak_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    logic rdy;
    rdy = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !vld[k] || rdy;
      rdy = en[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = vld[NSTG-1];

  gde_axis u_axis_x (
    .clk    (clk),
    .en     (en[2:0]),
    .point  (point_x),
    .center (center_x),
    .coef   (inv_two_var_x),
    .term   (term_x)
  );

  gde_axis u_axis_y (
    .clk    (clk),
    .en     (en[2:0]),
    .point  (point_y),
    .center (center_y),
    .coef   (inv_two_var_y),
    .term   (term_y)
  );

  assign arg_sum = {1'b0, term_x} + {1'b0, term_y};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      arg <= (|arg_sum[gde_pkg::TERM_W:gde_pkg::COORD_W]) ? {gde_pkg::COORD_W{1'b1}}
                                                          : arg_sum[gde_pkg::COORD_W-1:0];
    end
  end

  gde_exp #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS)
  ) u_exp (
    .clk     (clk),
    .en      (en[7:4]),
    .arg     (arg),
    .val     (val),
    .shift_n (shift_n)
  );

  assign shifted = prod >> shift_amt;
  assign density_next = huge ? '0 : shifted[gde_pkg::DENS_W-1:0];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      prod      <= gde_pkg::PROD_W'(peak_scale) * gde_pkg::PROD_W'(val);
      huge      <= 32'(shift_n) > 32'(gde_pkg::MAX_EXP_N);
      shift_amt <= gde_pkg::SHIFT_W'(gde_pkg::VAL_SHIFT) + gde_pkg::SHIFT_W'(shift_n);
    end
    if (en[9]) begin
      density     <= density_next;
      underflowed <= (density_next == '0) && (peak_scale != '0);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (density <= peak_scale))
    else $error("density exceeds the peak scale");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && underflowed) |-> (density == '0))
    else $error("underflow flagged on a nonzero density");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted transaction did not enter the first stage");

  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

endmodule

`default_nettype wire
